>>> design/assert_macros.svh
// Assertion helpers shared by the run queue RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset
`define RQ_ASSERT(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) else $error(msg);
// Check a property on every rising clock edge, reset included
`define RQ_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define RQ_ASSERT(lbl, clk_s, rst_n_s, prop, msg)
`define RQ_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif
`endif

>>> design/fsrq_pkg.sv
package fsrq_pkg;

	localparam int DEPTH_DEFAULT = 64;
	localparam int NICE_MAX      = 30;
	localparam int PERIOD_MAX    = 1023;
	localparam int WEIGHT_MAX    = 819;
	localparam int PROD_W        = 20;
	localparam logic [7:0] LATENCY_RESET = 8'd32;
	localparam logic [3:0] GRAN_RESET    = 4'd2;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_POP    = 2'd1,
		CMD_CHECK  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOT_RUN  = 2'd3
	} status_t;

	typedef enum logic {
		REG_LATENCY = 1'b0,
		REG_GRAN    = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_START,
		S_INS_SCAN,
		S_INS_LAST,
		S_HEAD_RD,
		S_HEAD_USE,
		S_MUL,
		S_DIV,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [31:0] vruntime;
		logic [5:0]  task_id;
		logic [9:0]  weight;
	} entry_t;

	// Weight for a nice level, clamped at the top of the table
	function automatic logic [9:0] weight_of(input logic [5:0] nice);
		logic [9:0] w;
		case ((nice > 6'(NICE_MAX)) ? 6'(NICE_MAX) : nice)
			6'd0:  w = 10'd819;
			6'd1:  w = 10'd655;
			6'd2:  w = 10'd524;
			6'd3:  w = 10'd419;
			6'd4:  w = 10'd335;
			6'd5:  w = 10'd268;
			6'd6:  w = 10'd214;
			6'd7:  w = 10'd171;
			6'd8:  w = 10'd137;
			6'd9:  w = 10'd109;
			6'd10: w = 10'd87;
			6'd11: w = 10'd70;
			6'd12: w = 10'd56;
			6'd13: w = 10'd45;
			6'd14: w = 10'd36;
			6'd15: w = 10'd28;
			6'd16: w = 10'd23;
			6'd17: w = 10'd18;
			6'd18: w = 10'd14;
			6'd19: w = 10'd11;
			6'd20: w = 10'd9;
			6'd21: w = 10'd7;
			6'd22: w = 10'd6;
			6'd23: w = 10'd4;
			6'd24: w = 10'd3;
			6'd25: w = 10'd3;
			6'd26: w = 10'd2;
			default: w = 10'd1;
		endcase
		return w;
	endfunction

endpackage

>>> design/fsrq_channels.sv
interface fsrq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [5:0]  task_id;
	logic [31:0] task_vruntime;
	logic [5:0]  nice_level;
	logic        head_runnable;
	logic [15:0] run_ticks;
	logic [9:0]  slice_limit;

	modport source (output valid, command, task_id, task_vruntime, nice_level,
		head_runnable, run_ticks, slice_limit, input ready);
	modport sink (input valid, command, task_id, task_vruntime, nice_level,
		head_runnable, run_ticks, slice_limit, output ready);
endinterface

interface fsrq_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [5:0] picked_task;
	logic [9:0] time_slice;
	logic [9:0] task_weight;
	logic       preempt;
	logic [6:0] queued_count;

	modport source (output valid, status, picked_task, time_slice, task_weight,
		preempt, queued_count, input ready);
	modport sink (input valid, status, picked_task, time_slice, task_weight,
		preempt, queued_count, output ready);
endinterface

>>> design/fsrq_store.sv
module fsrq_store
	import fsrq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  entry_t            wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output entry_t            rdata
);

	entry_t mem [DEPTH];
	entry_t rdata_q;

	// Write one entry per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/fsrq_divider.sv
module fsrq_divider
	import fsrq_pkg::*;
#(
	parameter int DEND_W = PROD_W,
	parameter int DSOR_W = 16,
	localparam int CNT_W = $clog2(DEND_W + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DEND_W-1:0] dividend,
	input  logic [DSOR_W-1:0] divisor,
	output logic              done,
	output logic [DEND_W-1:0] quotient
);

	logic [DSOR_W-1:0] rem_q;
	logic [DEND_W-1:0] quo_q;
	logic [DSOR_W-1:0] dsor_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DSOR_W:0]   shifted;
	logic              fits;

	// One restoring step per cycle while busy
	assign shifted = {rem_q, quo_q[DEND_W-1]};
	assign fits    = shifted >= {1'b0, dsor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			dsor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DSOR_W'(shifted - {1'b0, dsor_q}) : DSOR_W'(shifted);
			quo_q <= {quo_q[DEND_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> design/fair_share_run_queue.sv
// Insert: walks from the tail past each entry with a larger virtual runtime; an empty queue writes it at once.
// Pop: runs the 20-step serial slice divider; skips it when empty or head not runnable.
// Check reads the head only; full insert and unused command go straight to finish; a stalled output holds finish.
// One item in flight; the next can be taken in the cycle after the result is loaded.
// The store is a ring with one read and one write port; the insert walks it from the tail.
// Asynchronous active-low reset empties the queue and loads the register defaults.
`include "assert_macros.svh"
module fair_share_run_queue
	import fsrq_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEPTH_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          write_enable,
	input  logic          reg_index,
	input  logic [7:0]    write_data,
	fsrq_req_if.sink      req,
	fsrq_rsp_if.source    rsp
);

	localparam int ADDR_W = $clog2(QUEUE_DEPTH);
	localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int WT_W   = $clog2(QUEUE_DEPTH * WEIGHT_MAX + 1);

	state_t state_q, state_d;

	logic [7:0]        latency_q;
	logic [3:0]        gran_q;
	logic [9:0]        period_q;
	logic [OCC_W-1:0]  occ_q;
	logic [WT_W-1:0]   total_q;
	logic [ADDR_W-1:0] head_q;
	logic [ADDR_W-1:0] wr_idx_q;

	cmd_t        cmd_q;
	logic [5:0]  tid_q;
	logic [31:0] vrt_q;
	logic [9:0]  ins_w_q;
	logic        runnable_q;
	logic [15:0] run_q;
	logic [9:0]  lim_q;

	status_t     res_status_q;
	logic [5:0]  res_task_q;
	logic [9:0]  res_slice_q;
	logic [9:0]  res_weight_q;
	logic        res_preempt_q;
	logic [PROD_W-1:0] prod;

	logic        out_valid_q;
	logic [1:0]  out_status_q;
	logic [5:0]  out_task_q;
	logic [9:0]  out_slice_q;
	logic [9:0]  out_weight_q;
	logic        out_preempt_q;
	logic [6:0]  out_count_q;

	logic              st_we, st_re;
	logic [ADDR_W-1:0] st_waddr, st_raddr;
	entry_t            st_wdata, st_rdata, new_entry;
	logic              div_start, div_done;
	logic [PROD_W-1:0] div_quo;
	logic [3:0]        gran;
	logic [OCC_W+3:0]  occ_gran;
	logic              accept, finish_go, ins_greater;
	logic [9:0]        slice_cap;

	// Map a position in the queue to a ring address
	function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] head,
			input logic [ADDR_W-1:0] idx);
		logic [ADDR_W:0] sum;
		sum = {1'b0, head} + {1'b0, idx};
		if (sum >= (ADDR_W+1)'(QUEUE_DEPTH)) begin
			sum = sum - (ADDR_W+1)'(QUEUE_DEPTH);
		end
		return sum[ADDR_W-1:0];
	endfunction

	assign gran        = (gran_q == 4'd0) ? 4'd1 : gran_q;
	assign occ_gran    = occ_q * gran;
	assign accept      = req.valid && req.ready;
	assign finish_go   = !out_valid_q || rsp.ready;
	assign ins_greater = st_rdata.vruntime > vrt_q;
	assign new_entry   = '{vruntime: vrt_q, task_id: tid_q, weight: ins_w_q};
	assign slice_cap   = (div_quo > PROD_W'(period_q)) ? period_q : div_quo[9:0];
	assign req.ready   = (state_q == S_IDLE);
	// Product of period and popped weight, valid while the divider starts
	assign prod        = PROD_W'(period_q) * PROD_W'(res_weight_q);

	fsrq_store #(.DEPTH(QUEUE_DEPTH)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	fsrq_divider #(.DEND_W(PROD_W), .DSOR_W(WT_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod),
		.divisor  (total_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Next state and store access
	always_comb begin
		state_d   = state_q;
		st_we     = 1'b0;
		st_re     = 1'b0;
		st_waddr  = phys(head_q, wr_idx_q);
		st_raddr  = phys(head_q, wr_idx_q - 1'b1);
		st_wdata  = new_entry;
		div_start = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (cmd_t'(req.command))
						CMD_INSERT: state_d = (occ_q >= OCC_W'(QUEUE_DEPTH)) ?
							S_FINISH : S_INS_START;
						CMD_POP, CMD_CHECK: state_d = S_HEAD_RD;
						CMD_NONE: state_d = S_FINISH;
						default: state_d = S_FINISH;
					endcase
				end
			end
			S_INS_START: begin
				if (occ_q == '0) begin
					st_we    = 1'b1;
					st_waddr = head_q;
					state_d  = S_FINISH;
				end else begin
					st_re   = 1'b1;
					state_d = S_INS_SCAN;
				end
			end
			S_INS_SCAN: begin
				st_we = 1'b1;
				if (ins_greater) begin
					st_wdata = st_rdata;
					if (wr_idx_q == ADDR_W'(1)) begin
						state_d = S_INS_LAST;
					end else begin
						st_re    = 1'b1;
						st_raddr = phys(head_q, wr_idx_q - ADDR_W'(2));
					end
				end else begin
					state_d = S_FINISH;
				end
			end
			S_INS_LAST: begin
				st_we    = 1'b1;
				st_waddr = head_q;
				state_d  = S_FINISH;
			end
			S_HEAD_RD: begin
				st_re    = 1'b1;
				st_raddr = head_q;
				state_d  = S_HEAD_USE;
			end
			S_HEAD_USE: begin
				if (cmd_q == CMD_POP && occ_q != '0 && runnable_q) begin
					state_d = S_MUL;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_MUL: begin
				div_start = 1'b1;
				state_d   = S_DIV;
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (finish_go) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold state, configuration and queue bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			latency_q <= LATENCY_RESET;
			gran_q    <= GRAN_RESET;
			period_q  <= 10'(LATENCY_RESET);
			occ_q     <= '0;
			total_q   <= '0;
			head_q    <= '0;
		end else begin
			state_q <= state_d;
			if (write_enable) begin
				unique case (reg_idx_t'(reg_index))
					REG_LATENCY: latency_q <= write_data;
					REG_GRAN:    gran_q    <= write_data[3:0];
					default: ;
				endcase
			end
			// Commit an insert when the new entry lands
			if ((state_q == S_INS_START && occ_q == '0) || state_q == S_INS_LAST ||
					(state_q == S_INS_SCAN && !ins_greater)) begin
				occ_q   <= occ_q + 1'b1;
				total_q <= total_q + WT_W'(ins_w_q);
			end
			// Refresh the period on a nonempty pop when occupancy times granularity exceeds the latency
			if (state_q == S_HEAD_USE && cmd_q == CMD_POP && occ_q != '0 &&
					occ_gran > (OCC_W+4)'(latency_q)) begin
				period_q <= (occ_gran > (OCC_W+4)'(PERIOD_MAX)) ? 10'(PERIOD_MAX) :
					occ_gran[9:0];
			end
			// Drop the head once the slice is known
			if (state_q == S_DIV && div_done) begin
				occ_q   <= occ_q - 1'b1;
				total_q <= (total_q >= WT_W'(res_weight_q)) ?
					total_q - WT_W'(res_weight_q) : '0;
				head_q  <= (head_q == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
		end
	end

	// Capture the item and build its result
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q         <= cmd_t'(req.command);
			tid_q         <= req.task_id;
			vrt_q         <= req.task_vruntime;
			ins_w_q       <= weight_of(req.nice_level);
			runnable_q    <= req.head_runnable;
			run_q         <= req.run_ticks;
			lim_q         <= req.slice_limit;
			wr_idx_q      <= occ_q[ADDR_W-1:0];
			res_status_q  <= ST_DONE;
			res_task_q    <= '0;
			res_slice_q   <= '0;
			res_weight_q  <= '0;
			res_preempt_q <= 1'b0;
			if (cmd_t'(req.command) == CMD_INSERT) begin
				if (occ_q >= OCC_W'(QUEUE_DEPTH)) begin
					res_status_q <= ST_FULL;
				end else begin
					res_weight_q <= weight_of(req.nice_level);
				end
			end
		end
		if (state_q == S_INS_SCAN && ins_greater) begin
			wr_idx_q <= wr_idx_q - 1'b1;
		end
		if (state_q == S_HEAD_USE) begin
			if (cmd_q == CMD_POP) begin
				if (occ_q == '0) begin
					res_status_q <= ST_EMPTY;
				end else if (!runnable_q) begin
					res_status_q <= ST_NOT_RUN;
				end else begin
					res_task_q   <= st_rdata.task_id;
					res_weight_q <= st_rdata.weight;
				end
			end else begin
				if (run_q >= 16'(lim_q) && run_q >= 16'(gran)) begin
					res_preempt_q <= 1'b1;
				end else if (occ_q != '0 && runnable_q &&
						vrt_q > st_rdata.vruntime &&
						(run_q == 16'd0 || run_q >= 16'(gran))) begin
					res_preempt_q <= 1'b1;
				end
			end
		end
		if (state_q == S_DIV && div_done) begin
			res_slice_q <= (total_q == '0) ? 10'd0 : slice_cap;
		end
	end

	// Output register: advance on transfer, load when the item finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FINISH && finish_go) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && finish_go) begin
			out_status_q  <= res_status_q;
			out_task_q    <= res_task_q;
			out_slice_q   <= res_slice_q;
			out_weight_q  <= res_weight_q;
			out_preempt_q <= res_preempt_q;
			out_count_q   <= 7'(occ_q);
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.picked_task  = out_task_q;
	assign rsp.time_slice   = out_slice_q;
	assign rsp.task_weight  = out_weight_q;
	assign rsp.preempt      = out_preempt_q;
	assign rsp.queued_count = out_count_q;

	`RQ_ASSERT_ALWAYS(a_occ_bound, clk, !arst_n || occ_q <= OCC_W'(QUEUE_DEPTH), "occupancy above depth")
	`RQ_ASSERT(a_busy_after_accept, clk, arst_n, accept |=> state_q != S_IDLE, "accept left idle")
	`RQ_ASSERT(a_pop_shrinks, clk, arst_n, (state_q == S_DIV && div_done) |=> occ_q == $past(occ_q) - 1'b1, "pop did not shrink queue")
	`RQ_ASSERT(a_scan_nonempty, clk, arst_n, (state_q == S_INS_SCAN) |-> (occ_q != '0 && wr_idx_q != '0), "scan on empty queue")

endmodule
